[hw/rtl/ilid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants of the indexed list store
// Beat types, operation and status codes, and the control bundle that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 7;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int SWEEP_W  = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0]   CAP_COUNT = CNT_W'(CAPACITY);
  localparam logic [SWEEP_W-1:0] SWEEP_END = SWEEP_W'(CAPACITY);

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_APPEND = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

  typedef struct packed {
    logic [1:0]               operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         element_count;
  } out_beat_t;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         rd_pos;
  } cell_ctrl_t;

endpackage

[hw/rtl/ilid_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_cell: one slot of the element chain
// Holds one element. On insert, takes the left neighbor or the new value; on
// delete, takes the right neighbor. A read bus passes through every cell one
// stage per cycle and picks up this slot's element when its index matches.
// ----------------------------------------------------------------------------
module ilid_cell (
  input  logic                              clk,
  input  logic [ilid_pkg::SLOT_W-1:0]       cell_idx,
  input  ilid_pkg::cell_ctrl_t              ctrl,
  input  logic signed [ilid_pkg::DATA_W-1:0] left_elem,
  input  logic signed [ilid_pkg::DATA_W-1:0] right_elem,
  input  logic signed [ilid_pkg::DATA_W-1:0] bus_in,
  output logic signed [ilid_pkg::DATA_W-1:0] elem,
  output logic signed [ilid_pkg::DATA_W-1:0] bus_out
);

  logic [ilid_pkg::POS_W-1:0]         idx_ext;
  logic signed [ilid_pkg::DATA_W-1:0] elem_r, elem_nxt;
  logic signed [ilid_pkg::DATA_W-1:0] bus_r, bus_nxt;

  assign idx_ext = ilid_pkg::POS_W'(cell_idx);

  always_comb begin
    elem_nxt = elem_r;
    if (ctrl.ins) begin
      if (idx_ext > ctrl.pos) begin
        elem_nxt = left_elem;
      end else if (idx_ext == ctrl.pos) begin
        elem_nxt = ctrl.value;
      end
    end else if (ctrl.del) begin
      if (idx_ext >= ctrl.pos) begin
        elem_nxt = right_elem;
      end
    end
    bus_nxt = (idx_ext == ctrl.rd_pos) ? elem_r : bus_in;
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    bus_r  <= bus_nxt;
  end

  assign elem    = elem_r;
  assign bus_out = bus_r;

endmodule

[hw/rtl/indexed_list_insert_delete.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: ordered store of up to 64 signed words
// Chain of cells with insert, delete, append and read by position.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive in_beat and raise start; the beat is taken at a rising
//   edge with start high and busy low.
//   Result beat: out_beat is shown for exactly one cycle with out_valid high.
//   Every request gives one result beat; the receiver cannot stall it.
// Request flow:
//   Insert, delete, append and out-of-range reads: result in the cycle after
//   the request, busy stays low, a new request may follow every cycle.
//   In-range read: the read bus crosses the 64-cell chain one cell per cycle;
//   the result is registered when the sweep ends and busy is high until it
//   leaves, so no new request is taken while the read is under way.
// Reset:
//   rst_n low at a clock edge empties the store (count zero) and drops any
//   read under way. Element contents are not cleared; slots at or above the
//   count are never read.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ilid_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  output ilid_pkg::out_beat_t out_beat
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                              state_r, state_nxt;
  logic [ilid_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [ilid_pkg::POS_W-1:0]          rd_pos_r, rd_pos_nxt;
  logic [ilid_pkg::SWEEP_W-1:0]        sweep_r, sweep_nxt;
  logic                                out_valid_r, out_valid_nxt;
  ilid_pkg::out_beat_t                 out_beat_r, out_beat_nxt;

  logic                                accept;
  logic                                full;
  ilid_pkg::cell_ctrl_t                ctrl;
  logic signed [ilid_pkg::DATA_W-1:0]  elem [ilid_pkg::CAPACITY];
  logic signed [ilid_pkg::DATA_W-1:0]  bus  [ilid_pkg::CAPACITY];

  assign busy   = (state_r == S_READ);
  assign accept = start && !busy;
  assign full   = (count_r == ilid_pkg::CAP_COUNT);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_pos_nxt    = rd_pos_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = 1'b0;
    out_beat_nxt  = out_beat_r;
    ctrl          = '0;
    ctrl.value    = in_beat.item_value;
    ctrl.pos      = in_beat.position;
    ctrl.rd_pos   = rd_pos_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_beat_nxt.read_value = '0;
          out_beat_nxt.status     = ilid_pkg::ST_DONE;
          case (in_beat.operation)
            ilid_pkg::OP_READ: begin
              if (in_beat.position < count_r) begin
                rd_pos_nxt = in_beat.position;
                sweep_nxt  = '0;
                state_nxt  = S_READ;
              end else begin
                out_valid_nxt           = 1'b1;
                out_beat_nxt.read_value = ilid_pkg::READ_MISS;
                out_beat_nxt.status     = ilid_pkg::ST_RANGE;
              end
            end
            ilid_pkg::OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (in_beat.position > count_r) begin
                out_beat_nxt.status = ilid_pkg::ST_RANGE;
              end else if (full) begin
                out_beat_nxt.status = ilid_pkg::ST_FULL;
              end else begin
                ctrl.ins  = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            ilid_pkg::OP_DELETE: begin
              out_valid_nxt = 1'b1;
              if (in_beat.position < count_r) begin
                ctrl.del  = 1'b1;
                count_nxt = count_r - 1'b1;
              end else begin
                out_beat_nxt.status = ilid_pkg::ST_RANGE;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              ctrl.pos      = ilid_pkg::POS_W'(count_r);
              if (full) begin
                out_beat_nxt.status = ilid_pkg::ST_FULL;
              end else begin
                ctrl.ins  = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
          endcase
          out_beat_nxt.element_count = count_nxt;
        end
      end
      S_READ: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == ilid_pkg::SWEEP_END) begin
          out_valid_nxt              = 1'b1;
          out_beat_nxt.read_value    = bus[ilid_pkg::CAPACITY-1];
          out_beat_nxt.status        = ilid_pkg::ST_DONE;
          out_beat_nxt.element_count = count_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_pos_r   <= rd_pos_nxt;
    sweep_r    <= sweep_nxt;
    out_beat_r <= out_beat_nxt;
  end

  for (genvar g = 0; g < ilid_pkg::CAPACITY; g++) begin : g_cell
    logic signed [ilid_pkg::DATA_W-1:0] left_elem;
    logic signed [ilid_pkg::DATA_W-1:0] right_elem;
    logic signed [ilid_pkg::DATA_W-1:0] bus_in;

    if (g == 0) begin : g_head
      assign left_elem = '0;
      assign bus_in    = '0;
    end else begin : g_body
      assign left_elem = elem[g-1];
      assign bus_in    = bus[g-1];
    end

    if (g == ilid_pkg::CAPACITY - 1) begin : g_tail
      assign right_elem = '0;
    end else begin : g_next
      assign right_elem = elem[g+1];
    end

    ilid_cell u_cell (
      .clk        (clk),
      .cell_idx   (ilid_pkg::SLOT_W'(g)),
      .ctrl       (ctrl),
      .left_elem  (left_elem),
      .right_elem (right_elem),
      .bus_in     (bus_in),
      .elem       (elem[g]),
      .bus_out    (bus[g])
    );
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

[dv/indexed_list_insert_delete_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_test: self-checking bench for the indexed store
// Drives read, insert, delete and append beats through the start/busy
// handshake and predicts every result beat from a shadow copy of the
// sequence. The bench opens with edge cases on a short list, then runs
// random grow, shrink and mixed episodes that push the store to full and back
// to empty, under three sender idle settings.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_test;

  class list_scoreboard;
    logic signed [ilid_pkg::DATA_W-1:0] slots [ilid_pkg::CAPACITY];
    int                  fill;
    int                  peak;
    ilid_pkg::out_beat_t pending_results [$];
    int                  errors;
    int                  checked;
    int                  reads_hit;
    int                  inserts_done;
    int                  deletes_done;
    int                  appends_done;
    int                  range_flags;
    int                  full_flags;

    function void shift_in(int at, logic signed [ilid_pkg::DATA_W-1:0] value);
      int i;
      for (i = fill; i > at; i--) slots[i] = slots[i-1];
      slots[at] = value;
      fill++;
      if (fill > peak) peak = fill;
    endfunction

    function ilid_pkg::out_beat_t predict_result(ilid_pkg::in_beat_t b);
      ilid_pkg::out_beat_t r;
      int                  pos;
      int                  i;
      pos             = int'(b.position);
      r.read_value    = '0;
      r.status        = ilid_pkg::ST_DONE;
      case (b.operation)
        ilid_pkg::OP_READ: begin
          if (pos < fill) begin
            r.read_value = slots[pos];
            reads_hit++;
          end else begin
            r.read_value = ilid_pkg::READ_MISS;
            r.status     = ilid_pkg::ST_RANGE;
          end
        end
        ilid_pkg::OP_INSERT: begin
          if (pos > fill) begin
            r.status = ilid_pkg::ST_RANGE;
          end else if (fill >= ilid_pkg::CAPACITY) begin
            r.status = ilid_pkg::ST_FULL;
          end else begin
            shift_in(pos, b.item_value);
            inserts_done++;
          end
        end
        ilid_pkg::OP_DELETE: begin
          if (pos < fill) begin
            for (i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
            deletes_done++;
          end else begin
            r.status = ilid_pkg::ST_RANGE;
          end
        end
        default: begin
          if (fill >= ilid_pkg::CAPACITY) begin
            r.status = ilid_pkg::ST_FULL;
          end else begin
            shift_in(fill, b.item_value);
            appends_done++;
          end
        end
      endcase
      if (r.status == ilid_pkg::ST_RANGE) range_flags++;
      if (r.status == ilid_pkg::ST_FULL) full_flags++;
      r.element_count = ilid_pkg::CNT_W'(fill);
      return r;
    endfunction

    function void note_request(ilid_pkg::in_beat_t b);
      pending_results.push_back(predict_result(b));
    endfunction

    function void mismatch(string field, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(ilid_pkg::out_beat_t got);
      ilid_pkg::out_beat_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual read_value %0d status %0d count %0d",
                 $time, got.read_value, got.status, got.element_count);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.read_value !== want.read_value)
        mismatch("read_value", want.read_value, got.read_value);
      if (got.status !== want.status)
        mismatch("status", want.status, got.status);
      if (got.element_count !== want.element_count)
        mismatch("element_count", want.element_count, got.element_count);
    endfunction
  endclass

  typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ilid_pkg::in_beat_t  in_beat = '0;
  logic                out_valid;
  ilid_pkg::out_beat_t out_beat;

  list_scoreboard sb = new;

  indexed_list_insert_delete u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_beat);
  end

  function automatic ilid_pkg::in_beat_t make_request(
      logic [1:0] op, logic [ilid_pkg::POS_W-1:0] pos,
      logic signed [ilid_pkg::DATA_W-1:0] value);
    ilid_pkg::in_beat_t b;
    b.operation  = op;
    b.position   = pos;
    b.item_value = value;
    return b;
  endfunction

  function automatic logic signed [ilid_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic ilid_pkg::in_beat_t random_request(trend_t trend);
    logic [1:0] op;
    int         roll;
    int         pos;
    roll = $urandom_range(0, 99);
    case (trend)
      TREND_GROW:   op = roll < 35 ? ilid_pkg::OP_APPEND :
                         roll < 70 ? ilid_pkg::OP_INSERT :
                         roll < 85 ? ilid_pkg::OP_READ : ilid_pkg::OP_DELETE;
      TREND_SHRINK: op = roll < 10 ? ilid_pkg::OP_APPEND :
                         roll < 20 ? ilid_pkg::OP_INSERT :
                         roll < 40 ? ilid_pkg::OP_READ : ilid_pkg::OP_DELETE;
      default:      op = roll < 25 ? ilid_pkg::OP_APPEND :
                         roll < 50 ? ilid_pkg::OP_INSERT :
                         roll < 75 ? ilid_pkg::OP_READ : ilid_pkg::OP_DELETE;
    endcase
    if ($urandom_range(0, 99) < 12 || op == ilid_pkg::OP_APPEND)
      pos = $urandom_range(0, 127);
    else if (op == ilid_pkg::OP_INSERT)
      pos = $urandom_range(0, sb.fill);
    else
      pos = sb.fill == 0 ? 0 : $urandom_range(0, sb.fill - 1);
    return make_request(op, ilid_pkg::POS_W'(pos), pick_value());
  endfunction

  task automatic send_request(ilid_pkg::in_beat_t b, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      in_beat <= make_request(2'($urandom), ilid_pkg::POS_W'($urandom), $urandom);
      @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    sb.note_request(b);
  endtask

  task automatic run_phase(int idle_pct, int n_items);
    int     sent;
    int     k;
    int     len;
    int     tail;
    bit     reached;
    trend_t trend;
    sent  = 0;
    trend = TREND_GROW;
    while (sent < n_items) begin
      len  = $urandom_range(30, 90);
      tail = -1;
      for (k = 0; k < 400 && sent < n_items && tail != 0; k++) begin
        send_request(random_request(trend), idle_pct);
        sent++;
        case (trend)
          TREND_GROW:   reached = sb.fill == ilid_pkg::CAPACITY;
          TREND_SHRINK: reached = sb.fill == 0;
          default:      reached = k + 1 >= len;
        endcase
        if (tail > 0) tail--;
        else if (tail < 0 && reached) tail = 8;
      end
      trend = trend_t'($urandom_range(0, 2));
    end
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(make_request(ilid_pkg::OP_READ, 7'd0, 32'sd5), 19);
    send_request(make_request(ilid_pkg::OP_DELETE, 7'd0, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_INSERT, 7'd1, 32'sd9), 19);
    send_request(make_request(ilid_pkg::OP_INSERT, 7'd0, 32'sh7FFF_FFFF), 19);
    send_request(make_request(ilid_pkg::OP_INSERT, 7'd0, 32'sh8000_0000), 19);
    send_request(make_request(ilid_pkg::OP_APPEND, 7'd127, -32'sd1), 19);
    send_request(make_request(ilid_pkg::OP_INSERT, 7'd3, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_INSERT, 7'd2, 32'sh5A5A_5A5A), 19);
    send_request(make_request(ilid_pkg::OP_READ, 7'd0, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_READ, 7'd4, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_READ, 7'd2, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_READ, 7'd5, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_READ, 7'd127, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_INSERT, 7'd127, 32'sd7), 19);
    send_request(make_request(ilid_pkg::OP_DELETE, 7'd127, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_DELETE, 7'd5, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_DELETE, 7'd2, -32'sd1), 19);
    send_request(make_request(ilid_pkg::OP_DELETE, 7'd0, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_DELETE, 7'd2, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_READ, 7'd1, 32'sd0), 19);
    send_request(make_request(ilid_pkg::OP_READ, 7'd0, -32'sd1), 19);

    run_phase(19, 460);
    run_phase(47, 460);
    run_phase(0, 460);
    start <= 1'b0;

    waited = 0;
    while (sb.pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (70) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.errors += sb.pending_results.size();
      $display("%0t: %0d expected results never arrived", $time,
               sb.pending_results.size());
    end

    $display("Checked %0d result beats: %0d in-range reads, %0d inserts, %0d deletes,",
             sb.checked, sb.reads_hit, sb.inserts_done, sb.deletes_done);
    $display("%0d appends; flagged %0d out-of-range and %0d full; peak %0d of %0d entries.",
             sb.appends_done, sb.range_flags, sb.full_flags, sb.peak, ilid_pkg::CAPACITY);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
